// ----- sv/rdcw_pkg.sv -----
// shared types and constants for the range distinct count window block
`default_nettype none

package rdcw_pkg;

    localparam int ARRAY_DEPTH_DEF = 32768;
    localparam int VALUE_COUNT_DEF = 65536;
    localparam int QUEUE_DEPTH     = 4;
    localparam int RED_STEPS       = 2;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [1:0] {
        CMD_LOAD,
        CMD_QUERY,
        CMD_BAD
    } t_cmd_kind;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RED,
        S_LDWR,
        S_PLAN,
        S_ELEM,
        S_HIST,
        S_UPD
    } t_back_state;

endpackage

`default_nettype wire

// ----- sv/rdcw_front.sv -----
// front end: accepts requests, tracks loaded length, classifies into commands
`default_nettype none

module rdcw_front
    import rdcw_pkg::*;
#(
    parameter int ARRAY_DEPTH = ARRAY_DEPTH_DEF,
    parameter int LW          = $clog2(ARRAY_DEPTH + 1)
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_stall,
    input  wire logic            i_op,
    input  wire logic [14:0]     i_position,
    input  wire logic [15:0]     i_value,
    input  wire logic [14:0]     i_left,
    input  wire logic [14:0]     i_right,
    input  wire logic [15:0]     i_tag,
    input  wire logic            i_q_full,
    input  wire logic            i_clearing,
    output logic                 o_push,
    output t_cmd_kind            o_kind,
    output logic [LW-1:0]        o_a,
    output logic [LW-1:0]        o_b,
    output logic [15:0]          o_data
);

    logic          r_begun;
    logic          n_begun;
    logic [LW-1:0] r_len;
    logic [LW-1:0] n_len;
    logic          take;
    logic [31:0]   pos_ext;
    logic [31:0]   right_ext;
    logic          load_ok;
    logic          range_bad;

    assign o_in_stall = i_q_full | i_clearing;
    assign take       = i_in_valid & ~o_in_stall;
    assign pos_ext    = 32'(i_position);
    assign right_ext  = 32'(i_right);
    assign load_ok    = ~r_begun && (pos_ext < 32'(ARRAY_DEPTH));
    assign range_bad  = (i_left > i_right) || (right_ext >= 32'(r_len));

    always_comb begin
        n_begun = r_begun;
        n_len   = r_len;
        o_push  = 1'b0;
        o_kind  = CMD_LOAD;
        o_a     = LW'(i_position);
        o_b     = '0;
        o_data  = i_value;
        if (take) begin
            case (i_op)
                OP_LOAD: begin
                    if (load_ok) begin
                        o_push = 1'b1;
                        if (pos_ext + 32'd1 > 32'(r_len)) begin
                            n_len = LW'(pos_ext + 32'd1);
                        end
                    end
                end
                default: begin
                    n_begun = 1'b1;
                    o_push  = 1'b1;
                    o_data  = i_tag;
                    o_kind  = range_bad ? CMD_BAD : CMD_QUERY;
                    o_a     = LW'(i_left);
                    o_b     = LW'(right_ext + 32'd1);
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_begun <= 1'b0;
            r_len   <= '0;
        end else begin
            r_begun <= n_begun;
            r_len   <= n_len;
        end
    end

endmodule

`default_nettype wire

// ----- sv/rdcw_queue.sv -----
// short command queue between front and back
`default_nettype none

module rdcw_queue
    import rdcw_pkg::*;
#(
    parameter int WIDTH = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    output logic                  o_valid,
    input  wire logic             i_stall,
    output logic [WIDTH-1:0]      o_data
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] r_mem [QUEUE_DEPTH];
    logic [PW-1:0]    r_wr;
    logic [PW-1:0]    r_rd;
    logic [CW-1:0]    r_cnt;
    logic [PW-1:0]    n_wr;
    logic [PW-1:0]    n_rd;
    logic [CW-1:0]    n_cnt;
    logic             pop;

    assign o_full  = (r_cnt == CW'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign pop     = o_valid & ~i_stall;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (pop) begin
            n_rd = (r_rd == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        case ({i_push, pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

`default_nettype wire

// ----- sv/rdcw_back.sv -----
// back end: element store, value histogram, window walk and result register
`default_nettype none

module rdcw_back
    import rdcw_pkg::*;
#(
    parameter int ARRAY_DEPTH = ARRAY_DEPTH_DEF,
    parameter int VALUE_COUNT = VALUE_COUNT_DEF,
    parameter int LW          = $clog2(ARRAY_DEPTH + 1)
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_cmd_valid,
    output logic                 o_cmd_stall,
    input  wire t_cmd_kind       i_kind,
    input  wire logic [LW-1:0]   i_a,
    input  wire logic [LW-1:0]   i_b,
    input  wire logic [15:0]     i_data,
    output logic                 o_clearing,
    output logic                 o_out_valid,
    input  wire logic            i_out_stall,
    output logic [15:0]          o_distinct_count,
    output logic [15:0]          o_result_tag,
    output logic                 o_bad_range
);

    localparam int AW = (ARRAY_DEPTH > 1) ? $clog2(ARRAY_DEPTH) : 1;
    localparam int VW = (VALUE_COUNT > 1) ? $clog2(VALUE_COUNT) : 1;
    localparam int SW = (RED_STEPS > 1) ? $clog2(RED_STEPS) : 1;
    // reciprocal of the value count, quotient estimate is exact or one low
    localparam logic [31:0] RECIP = 32'((64'd1 << 32) / 64'(VALUE_COUNT));
    localparam logic [31:0] VC32  = 32'(VALUE_COUNT);
    localparam logic [15:0] VC16  = 16'(VALUE_COUNT);

    logic [VW-1:0] store [ARRAY_DEPTH];
    logic [LW-1:0] hist [VALUE_COUNT];

    t_back_state r_state, n_state;
    logic [VW-1:0] r_clr, n_clr;
    logic [LW-1:0] r_start, n_start;
    logic [LW-1:0] r_end, n_end;
    logic [LW-1:0] r_total, n_total;
    logic [LW-1:0] r_left, n_left;
    logic [LW-1:0] r_stop, n_stop;
    logic [LW-1:0] r_pos, n_pos;
    logic          r_add, n_add;
    logic [15:0]   r_tag, n_tag;
    logic [15:0]   r_red, n_red;
    logic [15:0]   r_quo, n_quo;
    logic [SW-1:0] r_step, n_step;
    logic [AW-1:0] r_wpos, n_wpos;
    logic          r_out_valid, n_out_valid;
    logic [15:0]   r_out_count, n_out_count;
    logic [15:0]   r_out_tag, n_out_tag;
    logic          r_out_bad, n_out_bad;
    logic [VW-1:0] r_elem;
    logic [LW-1:0] r_hcnt;

    logic          out_busy;
    logic          cmd_take;
    logic          grow_left, grow_right, shr_left, shr_right, any_move;
    logic [47:0]   red_prod;
    logic [15:0]   red_fix;
    logic          store_we;
    logic          hist_we;
    logic [VW-1:0] hist_waddr;
    logic [LW-1:0] hist_wdata;

    assign out_busy   = r_out_valid & i_out_stall;
    assign cmd_take   = i_cmd_valid & ~o_cmd_stall;
    assign grow_left  = r_start > r_left;
    assign grow_right = r_end < r_stop;
    assign shr_left   = r_start < r_left;
    assign shr_right  = r_end > r_stop;
    assign any_move   = grow_left | grow_right | shr_left | shr_right;
    assign red_prod   = {32'd0, r_red} * {16'd0, RECIP};
    assign red_fix    = ({16'd0, r_red} >= VC32) ? r_red - VC16 : r_red;
    assign o_clearing = (r_state == S_CLEAR);

    assign o_out_valid      = r_out_valid;
    assign o_distinct_count = r_out_count;
    assign o_result_tag     = r_out_tag;
    assign o_bad_range      = r_out_bad;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr == VW'(VALUE_COUNT - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (cmd_take) begin
                    unique case (i_kind)
                        CMD_LOAD:  n_state = S_RED;
                        CMD_QUERY: n_state = S_PLAN;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_RED: begin
                if (r_step == '0) begin
                    n_state = S_LDWR;
                end
            end
            S_LDWR: n_state = S_IDLE;
            S_PLAN: begin
                if (any_move) begin
                    n_state = S_ELEM;
                end else if (!out_busy) begin
                    n_state = S_IDLE;
                end
            end
            S_ELEM:  n_state = S_HIST;
            S_HIST:  n_state = S_UPD;
            S_UPD:   n_state = S_PLAN;
            default: n_state = S_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb begin
        o_cmd_stall = 1'b1;
        store_we    = 1'b0;
        hist_we     = 1'b0;
        hist_waddr  = r_elem;
        hist_wdata  = r_hcnt;
        n_clr       = r_clr;
        n_start     = r_start;
        n_end       = r_end;
        n_total     = r_total;
        n_left      = r_left;
        n_stop      = r_stop;
        n_pos       = r_pos;
        n_add       = r_add;
        n_tag       = r_tag;
        n_red       = r_red;
        n_quo       = r_quo;
        n_step      = r_step;
        n_wpos      = r_wpos;
        n_out_valid = r_out_valid & i_out_stall;
        n_out_count = r_out_count;
        n_out_tag   = r_out_tag;
        n_out_bad   = r_out_bad;
        unique case (r_state)
            S_CLEAR: begin
                hist_we    = 1'b1;
                hist_waddr = r_clr;
                hist_wdata = '0;
                n_clr      = r_clr + 1'b1;
            end
            S_IDLE: begin
                o_cmd_stall = (i_kind == CMD_BAD) && out_busy;
                if (cmd_take) begin
                    unique case (i_kind)
                        CMD_LOAD: begin
                            n_wpos = AW'(i_a);
                            n_red  = i_data;
                            n_step = SW'(RED_STEPS - 1);
                        end
                        CMD_QUERY: begin
                            n_left = i_a;
                            n_stop = i_b;
                            n_tag  = i_data;
                        end
                        default: begin
                            n_out_valid = 1'b1;
                            n_out_count = '0;
                            n_out_tag   = i_data;
                            n_out_bad   = 1'b1;
                        end
                    endcase
                end
            end
            S_RED: begin
                // quotient estimate, then remainder; last correction at the write
                if (r_step != '0) begin
                    n_quo = red_prod[47:32];
                end else begin
                    n_red = r_red - 16'(r_quo * VC16);
                end
                n_step = r_step - 1'b1;
            end
            S_LDWR: begin
                store_we = 1'b1;
            end
            S_PLAN: begin
                if (grow_left) begin
                    n_start = r_start - 1'b1;
                    n_pos   = r_start - 1'b1;
                    n_add   = 1'b1;
                end else if (grow_right) begin
                    n_pos = r_end;
                    n_end = r_end + 1'b1;
                    n_add = 1'b1;
                end else if (shr_left) begin
                    n_pos   = r_start;
                    n_start = r_start + 1'b1;
                    n_add   = 1'b0;
                end else if (shr_right) begin
                    n_end = r_end - 1'b1;
                    n_pos = r_end - 1'b1;
                    n_add = 1'b0;
                end else if (!out_busy) begin
                    n_out_valid = 1'b1;
                    n_out_count = 16'(r_total);
                    n_out_tag   = r_tag;
                    n_out_bad   = 1'b0;
                end
            end
            S_UPD: begin
                if (r_add) begin
                    hist_we    = 1'b1;
                    hist_wdata = r_hcnt + 1'b1;
                    if (r_hcnt == '0) begin
                        n_total = r_total + 1'b1;
                    end
                end else if (r_hcnt != '0) begin
                    hist_we    = 1'b1;
                    hist_wdata = r_hcnt - 1'b1;
                    if (r_hcnt == LW'(1)) begin
                        n_total = r_total - 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (store_we) begin
            store[r_wpos] <= VW'(red_fix);
        end
        r_elem <= store[r_pos[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (hist_we) begin
            hist[hist_waddr] <= hist_wdata;
        end
        r_hcnt <= hist[r_elem];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_start     <= '0;
            r_end       <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_start     <= n_start;
            r_end       <= n_end;
            r_total     <= n_total;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_left      <= n_left;
        r_stop      <= n_stop;
        r_pos       <= n_pos;
        r_add       <= n_add;
        r_tag       <= n_tag;
        r_red       <= n_red;
        r_quo       <= n_quo;
        r_step      <= n_step;
        r_wpos      <= n_wpos;
        r_out_count <= n_out_count;
        r_out_tag   <= n_out_tag;
        r_out_bad   <= n_out_bad;
    end

endmodule

`default_nettype wire

// ----- sv/range_distinct_count_window_top.sv -----
// top level of the range distinct count window block
//
//   channel  direction  handshake                 fields
//   in       input      i_in_valid / o_in_stall   op position value left right tag
//   out      output     o_out_valid / i_out_stall distinct_count result_tag bad_range
//
// after reset the histogram is cleared, one entry per cycle, with o_in_stall high
// until the clear is done. a load runs the value reduction steps in the back end, then
// writes the store. a query walks the window step by step; each step is a store read,
// a histogram read and a histogram write, one after another. a bad range goes straight
// to the output register. the front keeps accepting into a 4-entry queue while the back
// works, and a finished result waits in the output register while the back goes on.
`default_nettype none

module range_distinct_count_window_top
    import rdcw_pkg::*;
#(
    parameter int ARRAY_DEPTH = ARRAY_DEPTH_DEF,
    parameter int VALUE_COUNT = VALUE_COUNT_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic        i_op,
    input  wire logic [14:0] i_position,
    input  wire logic [15:0] i_value,
    input  wire logic [14:0] i_left,
    input  wire logic [14:0] i_right,
    input  wire logic [15:0] i_tag,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [15:0]      o_distinct_count,
    output logic [15:0]      o_result_tag,
    output logic             o_bad_range
);

    localparam int LW = $clog2(ARRAY_DEPTH + 1);
    localparam int KW = $bits(t_cmd_kind);
    localparam int QW = KW + 2 * LW + 16;

    logic            push;
    t_cmd_kind       f_kind;
    logic [LW-1:0]   f_a;
    logic [LW-1:0]   f_b;
    logic [15:0]     f_data;
    logic            q_full;
    logic            q_valid;
    logic [QW-1:0]   q_data;
    logic            b_stall;
    logic            clearing;

    rdcw_front #(
        .ARRAY_DEPTH (ARRAY_DEPTH),
        .LW          (LW)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_op       (i_op),
        .i_position (i_position),
        .i_value    (i_value),
        .i_left     (i_left),
        .i_right    (i_right),
        .i_tag      (i_tag),
        .i_q_full   (q_full),
        .i_clearing (clearing),
        .o_push     (push),
        .o_kind     (f_kind),
        .o_a        (f_a),
        .o_b        (f_b),
        .o_data     (f_data)
    );

    rdcw_queue #(
        .WIDTH (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_kind, f_a, f_b, f_data}),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_stall (b_stall),
        .o_data  (q_data)
    );

    rdcw_back #(
        .ARRAY_DEPTH (ARRAY_DEPTH),
        .VALUE_COUNT (VALUE_COUNT),
        .LW          (LW)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd_valid      (q_valid),
        .o_cmd_stall      (b_stall),
        .i_kind           (t_cmd_kind'(q_data[QW-1 -: KW])),
        .i_a              (q_data[2*LW+15 -: LW]),
        .i_b              (q_data[LW+15 -: LW]),
        .i_data           (q_data[15:0]),
        .o_clearing       (clearing),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_distinct_count (o_distinct_count),
        .o_result_tag     (o_result_tag),
        .o_bad_range      (o_bad_range)
    );

endmodule

`default_nettype wire
